// ===== rtl/swrl_pkg.sv =====
// Shared types and constants for the sliding window rate limiter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package swrl_pkg;

   localparam int COUNT_W    = 32;   // per-second byte count
   localparam int ELAPSED_W  = 8;
   localparam int REQ_W      = 24;   // bytes_moved, max_request, allowed_bytes
   localparam int DIGIT_BITS = 16;   // quotient bits produced per divider cycle

   localparam logic [COUNT_W-1:0] LIMIT_RESET = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AGE,
      ST_ADD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;       // capture request fields
      logic age;        // one aging step (shift or full clear)
      logic add;        // add bytes into the current second
      logic div_start;  // load the divider with the window sum
      logic div_step;   // one digit of the divider
      logic out_load;   // capture the result into the output registers
   } cmd_type;

   typedef struct packed {
      logic age_done;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/swrl_ctrl.sv =====
// Controller state machine of the sliding window rate limiter.
// Depends on swrl_pkg; drives the datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps

module swrl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  swrl_pkg::status_type status,
   output swrl_pkg::cmd_type    cmd
);
   import swrl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_AGE;
         end
         ST_AGE: begin
            if (status.age_done) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_AGE: begin
            cmd.age = !status.age_done;
         end
         ST_ADD: begin
            cmd.add       = 1'b1;
            cmd.div_start = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = !status.div_done;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/swrl_dpath.sv =====
// Datapath of the sliding window rate limiter: window shift line, running
// sum, divide by WINDOW one 16-bit digit a cycle through a reciprocal multiply,
// budget logic and result registers. Depends on swrl_pkg; sequenced by swrl_ctrl.
`timescale 1ns / 1ps

module swrl_dpath #(
   parameter int WINDOW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  swrl_pkg::cmd_type                cmd,
   output swrl_pkg::status_type             status,
   input  logic [swrl_pkg::ELAPSED_W-1:0]   req_seconds_elapsed,
   input  logic [swrl_pkg::REQ_W-1:0]       req_bytes_moved,
   input  logic [swrl_pkg::REQ_W-1:0]       req_max_request,
   input  logic                             csr_write,
   input  logic [swrl_pkg::COUNT_W-1:0]     csr_bytes_per_second_limit,
   output logic [swrl_pkg::COUNT_W-1:0]     rsp_average_rate,
   output logic [swrl_pkg::REQ_W-1:0]       rsp_allowed_bytes,
   output logic                             rsp_blocked
);
   import swrl_pkg::*;

   localparam int SUM_W     = COUNT_W + $clog2(WINDOW);
   localparam int DIV_W     = ((SUM_W + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
   localparam int DIV_STEPS = DIV_W / DIGIT_BITS;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int REM_W     = $clog2(WINDOW) + 1;

   // partial dividend {remainder, digit} and its exact reciprocal for / WINDOW
   localparam int TRY_W     = REM_W + DIGIT_BITS;
   localparam int RCP_SH    = TRY_W + $clog2(WINDOW);
   localparam int RCP_W     = TRY_W + 2;
   localparam int PROD_W    = TRY_W + RCP_W;
   localparam longint unsigned RCP_VAL = ((64'd1 << RCP_SH) + WINDOW - 1) / WINDOW;
   localparam logic [RCP_W-1:0] RECIP  = RCP_W'(RCP_VAL);

   logic [COUNT_W-1:0] counts_ff [0:WINDOW];
   logic [COUNT_W-1:0] counts_in [0:WINDOW];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W:0]     sum_wide;
   logic [CNT_W-1:0]   age_cnt_ff, age_cnt_in;
   logic               clear_ff, clear_in;
   logic [REQ_W-1:0]   moved_ff, maxreq_ff;
   logic [COUNT_W-1:0] limit_ff;
   logic [COUNT_W:0]   add_wide;
   logic [COUNT_W-1:0] cur_sat;

   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   logic [COUNT_W-1:0] headroom;
   logic               blocked;
   logic [REQ_W-1:0]   allowed;

   logic [COUNT_W-1:0] avg_ff;
   logic [REQ_W-1:0]   allowed_ff;
   logic               blocked_ff;

   // running sum of entries 1..WINDOW: one shift adds entry 0, drops the last
   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(counts_ff[0])
                   - (SUM_W+1)'(counts_ff[WINDOW]);

   assign add_wide = {1'b0, counts_ff[0]} + (COUNT_W+1)'(moved_ff);
   assign cur_sat  = add_wide[COUNT_W] ? '1 : add_wide[COUNT_W-1:0];

   assign status.age_done = (age_cnt_ff == '0) && !clear_ff;
   assign status.div_done = (dcnt_ff == '0);

   // aging control
   always_comb begin
      age_cnt_in = age_cnt_ff;
      clear_in   = clear_ff;
      if (cmd.load) begin
         if (req_seconds_elapsed > ELAPSED_W'(WINDOW)) begin
            clear_in   = 1'b1;
            age_cnt_in = '0;
         end else begin
            clear_in   = 1'b0;
            age_cnt_in = req_seconds_elapsed[CNT_W-1:0];
         end
      end else if (cmd.age) begin
         if (clear_ff) begin
            clear_in   = 1'b0;
            age_cnt_in = '0;
         end else begin
            age_cnt_in = age_cnt_ff - CNT_W'(1);
         end
      end
   end

   // window shift line and running sum
   always_comb begin
      counts_in = counts_ff;
      sum_in    = sum_ff;
      if (cmd.age) begin
         if (clear_ff) begin
            for (int i = 0; i <= WINDOW; i++) counts_in[i] = '0;
            sum_in = '0;
         end else begin
            counts_in[0] = '0;
            for (int i = 1; i <= WINDOW; i++) counts_in[i] = counts_ff[i-1];
            sum_in = sum_wide[SUM_W-1:0];
         end
      end else if (cmd.add) begin
         counts_in[0] = cur_sat;
      end
   end

   // long division by WINDOW, one DIGIT_BITS digit per cycle; the digit
   // quotient comes from a multiply by the rounded-up reciprocal, exact for
   // any partial dividend below 2**TRY_W
   always_comb begin
      logic [DIV_W-1:0]      q;
      logic [REM_W-1:0]      r;
      logic [TRY_W-1:0]      t;
      logic [PROD_W-1:0]     prod;
      logic [DIGIT_BITS-1:0] qd;
      logic [TRY_W-1:0]      back;
      q       = quo_ff;
      r       = rem_ff;
      t       = '0;
      prod    = '0;
      qd      = '0;
      back    = '0;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         q       = DIV_W'(sum_ff);
         r       = '0;
         dcnt_in = DCNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
         t       = {r, q[DIV_W-1 -: DIGIT_BITS]};
         prod    = PROD_W'(t) * PROD_W'(RECIP);
         qd      = prod[RCP_SH +: DIGIT_BITS];
         back    = t - TRY_W'(qd) * TRY_W'(WINDOW);
         r       = back[REM_W-1:0];
         q       = {q[DIV_W-DIGIT_BITS-1:0], qd};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
      quo_in = q;
      rem_in = r;
   end

   // budget from the updated current-second count
   assign blocked  = (counts_ff[0] >= limit_ff);
   assign headroom = limit_ff - counts_ff[0];
   assign allowed  = blocked ? '0 :
                     (headroom > COUNT_W'(maxreq_ff)) ? maxreq_ff : headroom[REQ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= WINDOW; i++) counts_ff[i] <= '0;
         sum_ff     <= '0;
         age_cnt_ff <= '0;
         clear_ff   <= 1'b0;
         dcnt_ff    <= '0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         counts_ff  <= counts_in;
         sum_ff     <= sum_in;
         age_cnt_ff <= age_cnt_in;
         clear_ff   <= clear_in;
         dcnt_ff    <= dcnt_in;
         if (csr_write) limit_ff <= csr_bytes_per_second_limit;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.load) begin
         moved_ff  <= req_bytes_moved;
         maxreq_ff <= req_max_request;
      end
      if (cmd.out_load) begin
         avg_ff     <= quo_ff[COUNT_W-1:0];
         allowed_ff <= allowed;
         blocked_ff <= blocked;
      end
   end

   assign rsp_average_rate  = avg_ff;
   assign rsp_allowed_bytes = allowed_ff;
   assign rsp_blocked       = blocked_ff;

endmodule

// ===== rtl/sliding_window_rate_limiter_core.sv =====
// Sliding window rate limiter, top level: controller plus datapath.
// Depends on swrl_pkg, swrl_ctrl and swrl_dpath.
//
// One request is processed at a time: it is accepted in idle, the window is
// aged, the bytes are added into the current second, the running sum is divided
// and the result is loaded into the response register, after which the block
// returns to idle and can accept the next request. A response that is still
// stalled when the next one is ready holds that one back until it leaves.
// Aging shifts the window one second per cycle, or clears it in a single step for
// gaps longer than WINDOW; the average comes from a running sum divided by
// WINDOW one 16-bit quotient digit per cycle through a reciprocal multiply.
// The limit register may be written at any time the block is idle;
// csr_ready is always high.
`timescale 1ns / 1ps

module sliding_window_rate_limiter_core #(
   parameter int WINDOW = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [swrl_pkg::ELAPSED_W-1:0]   req_seconds_elapsed,
   input  logic [swrl_pkg::REQ_W-1:0]       req_bytes_moved,
   input  logic [swrl_pkg::REQ_W-1:0]       req_max_request,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [swrl_pkg::COUNT_W-1:0]     rsp_average_rate,
   output logic [swrl_pkg::REQ_W-1:0]       rsp_allowed_bytes,
   output logic                             rsp_blocked,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [swrl_pkg::COUNT_W-1:0]     csr_bytes_per_second_limit
);
   import swrl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   swrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swrl_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .status                     (status),
      .req_seconds_elapsed        (req_seconds_elapsed),
      .req_bytes_moved            (req_bytes_moved),
      .req_max_request            (req_max_request),
      .csr_write                  (csr_valid && csr_ready),
      .csr_bytes_per_second_limit (csr_bytes_per_second_limit),
      .rsp_average_rate           (rsp_average_rate),
      .rsp_allowed_bytes          (rsp_allowed_bytes),
      .rsp_blocked                (rsp_blocked)
   );

endmodule

// ===== rtl/swrl_checker.sv =====
// Port-level checks for the sliding window rate limiter, bound to the top.
// Depends on swrl_pkg and sliding_window_rate_limiter_core.
`timescale 1ns / 1ps

module swrl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [swrl_pkg::COUNT_W-1:0]     rsp_average_rate,
   input logic [swrl_pkg::REQ_W-1:0]       rsp_allowed_bytes,
   input logic                             rsp_blocked
);
   import swrl_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_average_rate) && $stable(rsp_allowed_bytes)
         && $stable(rsp_blocked))
      else $error("stalled response changed");

   // an accepted request keeps the input stalled while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // a new response only appears at the end of a request's processing
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && rsp_stall) |-> $past(req_stall))
      else $error("response without a request in flight");

   // a blocked response grants no bytes
   a_blocked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blocked |-> rsp_allowed_bytes == '0)
      else $error("blocked response with nonzero budget");

endmodule

bind sliding_window_rate_limiter_core swrl_checker u_swrl_checker (.*);

// ===== verif/tb_sliding_window_rate_limiter_core.sv =====
// Self-checking testbench for sliding_window_rate_limiter_core: a queue-fed request driver,
// a response monitor and a transaction-level predictor of the byte window and budget.
// Depends on swrl_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_sliding_window_rate_limiter_core;

   localparam int WINDOW      = 8;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [swrl_pkg::ELAPSED_W-1:0] elapsed;
      logic [swrl_pkg::REQ_W-1:0]     moved;
      logic [swrl_pkg::REQ_W-1:0]     max_req;
   } meter_req_type;

   typedef struct packed {
      logic [swrl_pkg::COUNT_W-1:0] average;
      logic [swrl_pkg::REQ_W-1:0]   allowed;
      logic                         blocked;
   } meter_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [swrl_pkg::ELAPSED_W-1:0]   req_seconds_elapsed = '0;
   logic [swrl_pkg::REQ_W-1:0]       req_bytes_moved = '0;
   logic [swrl_pkg::REQ_W-1:0]       req_max_request = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [swrl_pkg::COUNT_W-1:0]     rsp_average_rate;
   logic [swrl_pkg::REQ_W-1:0]       rsp_allowed_bytes;
   logic                             rsp_blocked;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [swrl_pkg::COUNT_W-1:0]     csr_bytes_per_second_limit = '0;

   // predictor state
   logic [swrl_pkg::COUNT_W-1:0] window_counts [0:WINDOW];
   logic [swrl_pkg::COUNT_W-1:0] byte_limit;

   meter_req_type pending_requests [$];
   meter_rsp_type expected_responses [$];
   int            outstanding = 0;
   int            errors = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   sliding_window_rate_limiter_core #(.WINDOW(WINDOW)) dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_seconds_elapsed        (req_seconds_elapsed),
      .req_bytes_moved            (req_bytes_moved),
      .req_max_request            (req_max_request),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_average_rate           (rsp_average_rate),
      .rsp_allowed_bytes          (rsp_allowed_bytes),
      .rsp_blocked                (rsp_blocked),
      .csr_valid                  (csr_valid),
      .csr_ready                  (csr_ready),
      .csr_bytes_per_second_limit (csr_bytes_per_second_limit)
   );

   always #10 clock = ~clock;

   // Age the window, add the bytes, then derive average and budget.
   function automatic meter_rsp_type meter_step(meter_req_type r);
      int                             shift;
      int                             i;
      logic [swrl_pkg::COUNT_W:0]     grown;
      logic [63:0]                    total;
      logic [swrl_pkg::COUNT_W-1:0]   headroom;
      meter_rsp_type                  o;
      shift = (r.elapsed > WINDOW) ? WINDOW + 1 : int'(r.elapsed);
      for (i = WINDOW; i >= 0; i--) begin
         if (i >= shift) begin
            window_counts[i] = window_counts[i - shift];
         end else begin
            window_counts[i] = '0;
         end
      end
      grown = {1'b0, window_counts[0]} + (swrl_pkg::COUNT_W+1)'(r.moved);
      window_counts[0] = grown[swrl_pkg::COUNT_W] ? '1 : grown[swrl_pkg::COUNT_W-1:0];
      total = '0;
      for (i = 1; i <= WINDOW; i++) begin
         total = total + 64'(window_counts[i]);
      end
      total     = total / 64'(WINDOW);
      o.average = total[swrl_pkg::COUNT_W-1:0];
      o.blocked = (window_counts[0] >= byte_limit);
      headroom  = byte_limit - window_counts[0];
      if (o.blocked) begin
         o.allowed = '0;
      end else if (headroom > swrl_pkg::COUNT_W'(r.max_req)) begin
         o.allowed = r.max_req;
      end else begin
         o.allowed = headroom[swrl_pkg::REQ_W-1:0];
      end
      return o;
   endfunction

   function automatic meter_req_type random_request();
      meter_req_type r;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         r.elapsed = '0;
      end else if (pick < 80) begin
         r.elapsed = swrl_pkg::ELAPSED_W'(1);
      end else if (pick < 92) begin
         r.elapsed = swrl_pkg::ELAPSED_W'($urandom_range(2, WINDOW + 1));
      end else begin
         r.elapsed = swrl_pkg::ELAPSED_W'($urandom_range(WINDOW + 2, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.moved = '0;
      end else if (pick < 50) begin
         r.moved = swrl_pkg::REQ_W'($urandom_range(0, 'hFFFF));
      end else if (pick < 85) begin
         r.moved = swrl_pkg::REQ_W'($urandom_range(0, 'hFFFFFF));
      end else begin
         r.moved = swrl_pkg::REQ_W'($urandom_range('hF00000, 'hFFFFFF));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.max_req = '0;
      end else if (pick < 40) begin
         r.max_req = swrl_pkg::REQ_W'($urandom_range(0, 'hFFF));
      end else if (pick < 80) begin
         r.max_req = swrl_pkg::REQ_W'($urandom_range(0, 'hFFFFFF));
      end else begin
         r.max_req = '1;
      end
      return r;
   endfunction

   task automatic queue_request(input int elapsed, input int moved, input int max_req);
      meter_req_type r;
      r.elapsed = swrl_pkg::ELAPSED_W'(elapsed);
      r.moved   = swrl_pkg::REQ_W'(moved);
      r.max_req = swrl_pkg::REQ_W'(max_req);
      pending_requests.push_back(r);
      outstanding++;
   endtask

   task automatic queue_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         pending_requests.push_back(random_request());
         outstanding++;
      end
   endtask

   task automatic drain();
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   task automatic write_limit(input logic [swrl_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_bytes_per_second_limit <= value;
      do @(posedge clock); while (!csr_ready);
      byte_limit = value;
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin : drive_requests
      meter_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(
               meter_step({req_seconds_elapsed, req_bytes_moved, req_max_request}));
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_seconds_elapsed <= next_req.elapsed;
               req_bytes_moved <= next_req.moved;
               req_max_request <= next_req.max_req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : check_responses
      meter_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request pending: average_rate %0d", rsp_average_rate);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_average_rate !== want.average) begin
                  $error("average_rate: expected %0d, got %0d", want.average, rsp_average_rate);
                  errors++;
               end
               if (rsp_allowed_bytes !== want.allowed) begin
                  $error("allowed_bytes: expected %0d, got %0d", want.allowed, rsp_allowed_bytes);
                  errors++;
               end
               if (rsp_blocked !== want.blocked) begin
                  $error("blocked: expected %0d, got %0d", want.blocked, rsp_blocked);
                  errors++;
               end
               outstanding--;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_rate_limiter_core: mismatch");
         $finish;
      end
   end

   initial begin : run_phases
      int i;
      for (i = 0; i <= WINDOW; i++) begin
         window_counts[i] = '0;
      end
      byte_limit = swrl_pkg::LIMIT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 38;
      recv_stall_pct = 73;

      // directed, reset limit
      queue_request(0, 0, 0);
      queue_request(0, 'hFFFFFF, 'hFFFFFF);
      queue_request(0, 'hFFFFFF, 0);
      queue_request(1, 'h123456, 'hFFFFFF);
      queue_request(WINDOW, 0, 'hFFFFFF);          // shift by exactly the window
      queue_request(WINDOW + 1, 5, 10);            // long gap clears everything
      queue_request(255, 'hFFFFFF, 'hFFFFFF);
      queue_request(3, 'hAAAAAA, 'h555555);
      queue_request(2, 'h555555, 'hAAAAAA);
      drain();

      // zero limit: always blocked
      write_limit('0);
      queue_request(0, 0, 'hFFFFFF);
      queue_request(1, 100, 'hFFFFFF);
      queue_request(0, 'hFFFFFF, 'hFFFFFF);
      drain();

      // limit just past 24 bits: budget clamps, then hits the limit exactly
      write_limit(32'h0100_0000);
      queue_request(WINDOW + 1, 0, 'hFFFFFF);
      queue_request(0, 'hFFFFFF, 'hFFFFFF);
      queue_request(0, 1, 'hFFFFFF);
      queue_request(0, 1, 'hFFFFFF);
      queue_request(1, 0, 'hFFFFFF);
      drain();

      write_limit($urandom_range('h10_0000, 'h400_0000));
      queue_random(280);
      drain();

      send_idle_pct  = 73;
      recv_stall_pct = 38;
      write_limit($urandom >> $urandom_range(0, 8));
      queue_random(280);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_limit(swrl_pkg::LIMIT_RESET);
      // drive the current second into saturation, then push a second heavy one into the
      // window so the completed-second sum needs more than 32 bits
      for (i = 0; i < 260; i++) begin
         queue_request(0, $urandom_range('hFF0000, 'hFFFFFF), $urandom_range(0, 'hFFFFFF));
      end
      queue_request(1, $urandom_range('hFF0000, 'hFFFFFF), 'hFFFFFF);
      for (i = 0; i < 140; i++) begin
         queue_request(0, $urandom_range('hFF0000, 'hFFFFFF), $urandom_range(0, 'hFFFFFF));
      end
      queue_request(1, 0, 'hFFFFFF);
      queue_request(3, 0, 'hFFFFFF);
      queue_request(6, 0, 'hFFFFFF);
      drain();

      write_limit($urandom);
      queue_random(60);
      drain();

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("sliding_window_rate_limiter_core: match");
      end else begin
         $display("sliding_window_rate_limiter_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/swrl_pkg.sv
rtl/swrl_ctrl.sv
rtl/swrl_dpath.sv
rtl/sliding_window_rate_limiter_core.sv
rtl/swrl_checker.sv
verif/tb_sliding_window_rate_limiter_core.sv
